FILE: rtl/core/sparse_vector_entry_table_defines.svh
// ----------------------------------------------------------------------------
// Sparse vector entry table: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef SPARSE_VECTOR_ENTRY_TABLE_DEFINES_SVH
`define SPARSE_VECTOR_ENTRY_TABLE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds on that edge.
`define SVET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define SVET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/svet_pkg.sv
// ----------------------------------------------------------------------------
// Sparse vector entry table package
// Sizes, codes and types shared by the table's sequencer, datapath and checker.
// ----------------------------------------------------------------------------
package svet_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int INDEX_WIDTH = 24;
  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DIM_WIDTH   = INDEX_WIDTH + 1;
  localparam int ADDR_WIDTH  = $clog2(MAX_ENTRIES);
  localparam int COUNT_WIDTH = $clog2(MAX_ENTRIES + 1);

  localparam logic [DIM_WIDTH-1:0]   DIM_RESET  = {1'b1, {INDEX_WIDTH{1'b0}}};
  localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(MAX_ENTRIES);
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX  = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] VALUE_MIN  = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_GET   = 2'd1,
    OP_SCALE = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_SCALE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] position;
    logic [VALUE_WIDTH-1:0] amount;
  } entry_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0]  addr;
    logic [INDEX_WIDTH-1:0] position;
  } scale_tag_t;

  typedef struct packed {
    logic                   valid;
    status_t                status;
    logic [VALUE_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0] total;
  } result_t;

endpackage

FILE: rtl/core/svet_ram.sv
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module svet_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/svet_mul.sv
// ----------------------------------------------------------------------------
// Q16.16 scaling multiplier
// Two-stage pipe: signed product, then truncate toward zero and saturate.
// ----------------------------------------------------------------------------
module svet_mul (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic signed [svet_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic signed [svet_pkg::VALUE_WIDTH-1:0] factor,
  input  svet_pkg::scale_tag_t                   in_tag,
  output logic                                   out_valid,
  output logic [svet_pkg::VALUE_WIDTH-1:0]        out_value,
  output svet_pkg::scale_tag_t                   out_tag,
  output logic                                   busy
);

  localparam int PW = 2 * svet_pkg::VALUE_WIDTH;
  localparam int QW = PW - svet_pkg::FRAC_BITS;
  localparam int VW = svet_pkg::VALUE_WIDTH;

  logic                 prod_valid;
  logic signed [PW-1:0] prod;
  svet_pkg::scale_tag_t prod_tag;
  logic        [QW-1:0] quot;
  logic     [QW-VW:0]   quot_hi;
  logic        [VW-1:0] sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod      <= in_value * factor;
    prod_tag  <= in_tag;
    out_value <= sat;
    out_tag   <= prod_tag;
  end

  // Arithmetic shift rounds down; bump negatives with a nonzero fraction.
  always_comb begin
    quot = prod[PW-1:svet_pkg::FRAC_BITS] +
           QW'(prod[PW-1] && (prod[svet_pkg::FRAC_BITS-1:0] != '0));
    quot_hi = quot[QW-1:VW-1];
    if ((&quot_hi) || !(|quot_hi)) begin
      sat = quot[VW-1:0];
    end else if (quot[QW-1]) begin
      sat = svet_pkg::VALUE_MIN;
    end else begin
      sat = svet_pkg::VALUE_MAX;
    end
  end

  assign busy = prod_valid || out_valid;

endmodule

FILE: rtl/core/svet_ctrl.sv
// ----------------------------------------------------------------------------
// Sparse vector entry table sequencer
// Scans, shifts and rescales the entry RAM one entry per cycle.
// ----------------------------------------------------------------------------
module svet_ctrl (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              opcode,
  input  logic [svet_pkg::INDEX_WIDTH-1:0]         element_index,
  input  logic signed [svet_pkg::VALUE_WIDTH-1:0]  element_value,
  input  logic signed [svet_pkg::VALUE_WIDTH-1:0]  scale_factor,
  input  logic [svet_pkg::DIM_WIDTH-1:0]           dimension,
  input  logic                                    out_free,
  output svet_pkg::result_t                       result,
  output logic [svet_pkg::ADDR_WIDTH-1:0]          ram_rd_addr,
  input  svet_pkg::entry_t                        ram_rd_data,
  output logic                                    ram_wr_en,
  output logic [svet_pkg::ADDR_WIDTH-1:0]          ram_wr_addr,
  output svet_pkg::entry_t                        ram_wr_data
);

  localparam int AW = svet_pkg::ADDR_WIDTH;
  localparam int CW = svet_pkg::COUNT_WIDTH;

  svet_pkg::state_t  state;
  svet_pkg::state_t  state_next;
  svet_pkg::opcode_t op;
  svet_pkg::status_t res_status;

  logic [CW-1:0]                        count;
  logic [CW-1:0]                        ptr;
  logic                                 rd_valid;
  logic [AW-1:0]                        rd_addr;
  logic [svet_pkg::INDEX_WIDTH-1:0]      idx;
  logic signed [svet_pkg::VALUE_WIDTH-1:0] val;
  logic signed [svet_pkg::VALUE_WIDTH-1:0] fac;
  logic [svet_pkg::VALUE_WIDTH-1:0]      res_value;

  logic accept;
  logic in_range;
  logic match;
  logic scan_done;
  logic set_zero;
  logic is_set;
  logic append;
  logic issue;
  logic mul_in_valid;
  logic mul_out_valid;
  logic mul_busy;
  logic [svet_pkg::VALUE_WIDTH-1:0] mul_out_value;
  svet_pkg::scale_tag_t mul_out_tag;

  assign in_stall  = (state != svet_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_range  = ({1'b0, element_index} < dimension);
  assign match     = rd_valid && (ram_rd_data.position == idx);
  assign scan_done = (ptr >= count) && !rd_valid;
  assign set_zero  = (val == '0);
  assign is_set    = (op == svet_pkg::OP_SET);
  assign append    = is_set && !set_zero && (count != svet_pkg::FULL_COUNT);
  assign ram_rd_addr = ptr[AW-1:0];

  svet_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_in_valid),
    .in_value  (ram_rd_data.amount),
    .factor    (fac),
    .in_tag    ({rd_addr, ram_rd_data.position}),
    .out_valid (mul_out_valid),
    .out_value (mul_out_value),
    .out_tag   (mul_out_tag),
    .busy      (mul_busy)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      svet_pkg::S_IDLE: begin
        if (accept) begin
          case (svet_pkg::opcode_t'(opcode))
            svet_pkg::OP_SET,
            svet_pkg::OP_GET:   state_next = in_range ? svet_pkg::S_SCAN : svet_pkg::S_FINISH;
            svet_pkg::OP_SCALE: state_next = svet_pkg::S_SCALE;
            default:            state_next = svet_pkg::S_FINISH;
          endcase
        end
      end
      svet_pkg::S_SCAN: begin
        if (match) begin
          state_next = (is_set && set_zero) ? svet_pkg::S_SHIFT : svet_pkg::S_FINISH;
        end else if (scan_done) begin
          state_next = svet_pkg::S_FINISH;
        end
      end
      svet_pkg::S_SHIFT: begin
        if (scan_done) begin
          state_next = svet_pkg::S_FINISH;
        end
      end
      svet_pkg::S_SCALE: begin
        if (scan_done && !mul_busy) begin
          state_next = svet_pkg::S_FINISH;
        end
      end
      svet_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = svet_pkg::S_IDLE;
        end
      end
      default: state_next = svet_pkg::S_IDLE;
    endcase
  end

  // Read issue and RAM write port
  always_comb begin
    issue        = 1'b0;
    mul_in_valid = 1'b0;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = rd_addr;
    ram_wr_data  = ram_rd_data;
    case (state)
      svet_pkg::S_SCAN: begin
        issue = !match && (ptr < count);
        if (match && is_set && !set_zero) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = rd_addr;
          ram_wr_data = {ram_rd_data.position, val};
        end else if (scan_done && append) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = count[AW-1:0];
          ram_wr_data = {idx, val};
        end
      end
      svet_pkg::S_SHIFT: begin
        // Move entry i+1 down into slot i as each read returns.
        issue = (ptr < count);
        if (rd_valid) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = rd_addr - AW'(1);
          ram_wr_data = ram_rd_data;
        end
      end
      svet_pkg::S_SCALE: begin
        issue        = (ptr < count);
        mul_in_valid = rd_valid;
        if (mul_out_valid) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = mul_out_tag.addr;
          ram_wr_data = {mul_out_tag.position, mul_out_value};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= svet_pkg::S_IDLE;
      count    <= '0;
      ptr      <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (issue) begin
        ptr <= ptr + CW'(1);
      end
      case (state)
        svet_pkg::S_IDLE: begin
          if (accept) begin
            ptr <= '0;
          end
        end
        svet_pkg::S_SCAN: begin
          if (match && is_set && set_zero) begin
            ptr <= CW'(rd_addr) + CW'(1);
          end else if (scan_done && append) begin
            count <= count + CW'(1);
          end
        end
        svet_pkg::S_SHIFT: begin
          if (scan_done) begin
            count <= count - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= ptr[AW-1:0];
    if (accept) begin
      op        <= svet_pkg::opcode_t'(opcode);
      idx       <= element_index;
      val       <= element_value;
      fac       <= scale_factor;
      res_value <= '0;
      if ((svet_pkg::opcode_t'(opcode) == svet_pkg::OP_SET ||
           svet_pkg::opcode_t'(opcode) == svet_pkg::OP_GET) && !in_range) begin
        res_status <= svet_pkg::ST_RANGE;
      end else begin
        res_status <= svet_pkg::ST_OK;
      end
    end
    if (state == svet_pkg::S_SCAN) begin
      if (match && op == svet_pkg::OP_GET) begin
        res_value <= ram_rd_data.amount;
      end
      if (scan_done && is_set && !set_zero && count == svet_pkg::FULL_COUNT) begin
        res_status <= svet_pkg::ST_FULL;
      end
    end
  end

  assign result.valid  = (state == svet_pkg::S_FINISH);
  assign result.status = res_status;
  assign result.value  = res_value;
  assign result.total  = count;

endmodule

FILE: rtl/core/sparse_vector_entry_table.sv
// ----------------------------------------------------------------------------
// Sparse vector entry table
// Unsorted (index, value) list of a sparse Q16.16 vector held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word per operation: set
//   (opcode 0), get (1), scale (2) or no-op (3). Each word yields exactly one
//   result word on the output channel (out_valid / out_stall) with status,
//   read_value and entry_total, in input order.
//   dimension_we / dimension_wdata load the vector length; write it only
//   while no operation is in flight.
//   A no-op or an out-of-range index does not walk the list. Get and update
//   walk it up to the matching slot k; a miss, a delete and a scale walk all
//   N stored entries. One RAM read port walks the list one entry per cycle,
//   so the list length sets how long each word takes.
//   The result lands in an output register; the next word is taken while that
//   result waits. While out_stall is high, hold the result; a following word
//   finishes and then waits until the output register frees.
//   Reset empties the table (count to zero, no clearing pass: only slots below
//   the count are ever read) and sets dimension to 2^24.
// ----------------------------------------------------------------------------
module sparse_vector_entry_table (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              opcode,
  input  logic [svet_pkg::INDEX_WIDTH-1:0]         element_index,
  input  logic signed [svet_pkg::VALUE_WIDTH-1:0]  element_value,
  input  logic signed [svet_pkg::VALUE_WIDTH-1:0]  scale_factor,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [1:0]                              status,
  output logic signed [svet_pkg::VALUE_WIDTH-1:0]  read_value,
  output logic [svet_pkg::COUNT_WIDTH-1:0]         entry_total,
  input  logic                                    dimension_we,
  input  logic [svet_pkg::DIM_WIDTH-1:0]           dimension_wdata
);

  logic [svet_pkg::DIM_WIDTH-1:0]  dimension;
  logic                            out_free;
  svet_pkg::result_t               result;
  logic [svet_pkg::ADDR_WIDTH-1:0] ram_rd_addr;
  svet_pkg::entry_t                ram_rd_data;
  logic                            ram_wr_en;
  logic [svet_pkg::ADDR_WIDTH-1:0] ram_wr_addr;
  svet_pkg::entry_t                ram_wr_data;

  // Vector length register
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= svet_pkg::DIM_RESET;
    end else if (dimension_we) begin
      dimension <= dimension_wdata;
    end
  end

  // Output register frees when empty or being taken this cycle.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Advance the payload only on a load; hold it while stalled.
  always_ff @(posedge clk) begin
    if (result.valid && out_free) begin
      status      <= result.status;
      read_value  <= result.value;
      entry_total <= result.total;
    end
  end

  svet_ram #(
    .WIDTH ($bits(svet_pkg::entry_t)),
    .DEPTH (svet_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  svet_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .element_index (element_index),
    .element_value (element_value),
    .scale_factor  (scale_factor),
    .dimension     (dimension),
    .out_free      (out_free),
    .result        (result),
    .ram_rd_addr   (ram_rd_addr),
    .ram_rd_data   (ram_rd_data),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data)
  );

endmodule

FILE: rtl/core/svet_checker.sv
// ----------------------------------------------------------------------------
// Sparse vector entry table port checker
// Watches the top-level ports for table and handshake consistency.
// ----------------------------------------------------------------------------
`include "sparse_vector_entry_table_defines.svh"

module svet_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic [1:0]                              status,
  input logic signed [svet_pkg::VALUE_WIDTH-1:0]  read_value,
  input logic [svet_pkg::COUNT_WIDTH-1:0]         entry_total
);

  // An accepted word keeps the block busy on the next cycle.
  `SVET_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no busy after accept")

  // A full-table report only comes with a full table.
  `SVET_ASSERT_NOW(a_full_total, out_valid && status == svet_pkg::ST_FULL, entry_total == svet_pkg::FULL_COUNT, "full status with room left")

  // Any error result reads as zero.
  `SVET_ASSERT_NOW(a_error_zero, out_valid && status != svet_pkg::ST_OK, read_value == '0, "error result with nonzero value")

  // A stalled result stays up.
  `SVET_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid, "result dropped under stall")

endmodule

bind sparse_vector_entry_table svet_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .read_value  (read_value),
  .entry_total (entry_total)
);
